### hw/rtl/pbts_pkg.sv
// Package for the priority bitmap task scheduler.
// Holds sizes, command and state codes, and the record types shared by all modules.
package pbts_pkg;

   localparam int NUM_TASKS  = 32;
   localparam int TASK_BITS  = 5;
   localparam int NUM_PRIOS  = 32;
   localparam int PRIO_BITS  = 5;
   localparam int TICK_BITS  = 32;
   localparam int LINK_BITS  = TASK_BITS + 1;
   localparam int EPOCH_BITS = 16;
   localparam int CFG_BITS   = 15;
   localparam int WOKEN_BITS = 6;
   localparam int QADDR_BITS = PRIO_BITS + 1;

   localparam logic [TASK_BITS-1:0]  IDLE_TASK     = '0;
   localparam logic [PRIO_BITS-1:0]  MAX_PRIO      = PRIO_BITS'(NUM_PRIOS - 1);
   localparam logic [CFG_BITS-1:0]   DEFAULT_EPOCH = CFG_BITS'(10);
   localparam logic [LINK_BITS-1:0]  LINK_NIL      = {1'b1, {TASK_BITS{1'b0}}};
   localparam logic [TICK_BITS-1:0]  NEVER         = '1;
   localparam logic [EPOCH_BITS-1:0] EPOCH_MIN     = {1'b1, {(EPOCH_BITS-1){1'b0}}};

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_SCHED = 2'd1,
      CMD_READY = 2'd2,
      CMD_DELAY = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      WH_NONE  = 2'd0,
      WH_QUEUE = 2'd1,
      WH_DELAY = 2'd2
   } where_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_T_EPOCH,
      ST_T_ADV,
      ST_T_REFR,
      ST_T_CHK,
      ST_T_WLOOP,
      ST_T_WCHK,
      ST_S_HEAD,
      ST_S_PUSH,
      ST_S_CHK,
      ST_S_OLD,
      ST_D_SET,
      ST_W_STEP,
      ST_W_CMP,
      ST_W_LINK,
      ST_W_LINK2,
      ST_PUSH_START,
      ST_PUSH_TAIL,
      ST_PUSH_LINK,
      ST_RM_A,
      ST_RM_B,
      ST_FINISH
   } state_type;

   // One task record in the task table.
   typedef struct packed {
      logic [LINK_BITS-1:0]  next;
      logic [LINK_BITS-1:0]  prev;
      logic [PRIO_BITS-1:0]  prio;
      logic                  round;
      logic [EPOCH_BITS-1:0] epoch;
      logic [TICK_BITS-1:0]  wake;
   } task_rec_type;

   // Field write enables of the task table.
   typedef struct packed {
      logic next;
      logic prev;
      logic prio;
      logic round;
      logic epoch;
      logic wake;
   } rec_we_type;

   typedef struct packed {
      logic [TASK_BITS-1:0] head;
      logic [TASK_BITS-1:0] tail;
   } q_entry_type;

   typedef struct packed {
      logic head;
      logic tail;
   } q_we_type;

   typedef struct packed {
      cmd_type               command;
      logic [TASK_BITS-1:0]  task_id;
      logic [PRIO_BITS-1:0]  priority_req;
      logic                  to_next_round;
      logic [31:0]           delay_ticks;
   } item_type;

   typedef struct packed {
      logic                  status;
      logic                  switched;
      logic [TASK_BITS-1:0]  running_task;
      logic [WOKEN_BITS-1:0] woken_count;
      logic                  resched_pending;
   } res_type;

   // Highest set bit of a ready bitmap.
   function automatic logic [PRIO_BITS-1:0] hi_bit(input logic [NUM_PRIOS-1:0] m);
      logic [PRIO_BITS-1:0] p;
      p = '0;
      for (int i = 0; i < NUM_PRIOS; i++) begin
         if (m[i]) p = PRIO_BITS'(i);
      end
      return p;
   endfunction

endpackage

### hw/rtl/priority_bitmap_task_scheduler.sv
// Priority bitmap task scheduler, top level.
// An item's run time grows with each task a tick wakes and with each wake-list entry a delay
// walks past; the single read port of the task table sets this. One item at a time.
// Reset (synchronous) clears all control state at once; the memories need no clearing pass.
module priority_bitmap_task_scheduler (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_command,
   input  logic [4:0]                        req_task_id,
   input  logic [4:0]                        req_priority_req,
   input  logic                              req_to_next_round,
   input  logic [31:0]                       req_delay_ticks,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_status,
   output logic                              rsp_switched,
   output logic [4:0]                        rsp_running_task,
   output logic [5:0]                        rsp_woken_count,
   output logic                              rsp_resched_pending,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [14:0]                       csr_data
);
   import pbts_pkg::*;

   logic in_full_ff, in_full_in;
   item_type in_item_ff, in_item_in;
   logic out_full_ff, out_full_in;
   res_type out_res_ff, out_res_in;
   logic [CFG_BITS-1:0] epoch_cfg_ff, epoch_cfg_in;

   logic core_idle, core_start, core_res_valid, core_res_ready;
   res_type core_res;

   assign core_start     = in_full_ff && core_idle;
   assign core_res_ready = !out_full_ff;

   pbts_core u_core (
      .clock         (clock),
      .reset         (reset),
      .start         (core_start),
      .item          (in_item_ff),
      .default_epoch (epoch_cfg_ff),
      .idle          (core_idle),
      .res_valid     (core_res_valid),
      .res_ready     (core_res_ready),
      .res           (core_res)
   );

   // Input item buffer, output result register and the epoch register.
   always_comb begin
      in_full_in  = in_full_ff;
      in_item_in  = in_item_ff;
      out_full_in = out_full_ff;
      out_res_in  = out_res_ff;
      epoch_cfg_in = epoch_cfg_ff;
      if (req_valid && !req_stall) begin
         in_full_in               = 1'b1;
         in_item_in.command       = cmd_type'(req_command);
         in_item_in.task_id       = req_task_id;
         in_item_in.priority_req  = req_priority_req;
         in_item_in.to_next_round = req_to_next_round;
         in_item_in.delay_ticks   = req_delay_ticks;
      end else if (core_start) begin
         in_full_in = 1'b0;
      end
      if (core_res_valid && core_res_ready) begin
         out_full_in = 1'b1;
         out_res_in  = core_res;
      end else if (out_full_ff && !rsp_stall) begin
         out_full_in = 1'b0;
      end
      if (csr_valid && csr_ready) epoch_cfg_in = csr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_full_ff   <= 1'b0;
         out_full_ff  <= 1'b0;
         epoch_cfg_ff <= DEFAULT_EPOCH;
      end else begin
         in_full_ff   <= in_full_in;
         out_full_ff  <= out_full_in;
         epoch_cfg_ff <= epoch_cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   assign req_stall           = in_full_ff;
   assign csr_ready           = 1'b1;
   assign rsp_valid           = out_full_ff;
   assign rsp_status          = out_res_ff.status;
   assign rsp_switched        = out_res_ff.switched;
   assign rsp_running_task    = out_res_ff.running_task;
   assign rsp_woken_count     = out_res_ff.woken_count;
   assign rsp_resched_pending = out_res_ff.resched_pending;

`ifndef SYNTHESIS
   // A taken item fills the buffer, so the next cycle stalls.
   a_take_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input buffer did not fill after an item was taken");

   // The idle task always reports a pending reschedule.
   a_idle_resched: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_running_task == IDLE_TASK |-> rsp_resched_pending)
      else $error("idle task reported without reschedule mark");

   // A switch only comes from a schedule request, which neither rejects nor wakes.
   a_switch_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_switched |-> !rsp_status && rsp_woken_count == '0)
      else $error("switch reported together with reject or wake count");
`endif
endmodule

### hw/rtl/pbts_task_ram.sv
// Task table memory: one record per task, one read and one write port.
// Read data is registered; writes carry per-field enables. Uses pbts_pkg.
module pbts_task_ram (
   input  logic                                clock,
   input  logic                                rd_en,
   input  logic [pbts_pkg::TASK_BITS-1:0]      rd_addr,
   output pbts_pkg::task_rec_type              rd_data,
   input  pbts_pkg::rec_we_type                wr_en,
   input  logic [pbts_pkg::TASK_BITS-1:0]      wr_addr,
   input  pbts_pkg::task_rec_type              wr_data
);
   import pbts_pkg::*;

   task_rec_type rec_mem [NUM_TASKS];
   task_rec_type rd_data_ff;

   // Field-wise writes.
   always_ff @(posedge clock) begin
      if (wr_en.next)  rec_mem[wr_addr].next  <= wr_data.next;
      if (wr_en.prev)  rec_mem[wr_addr].prev  <= wr_data.prev;
      if (wr_en.prio)  rec_mem[wr_addr].prio  <= wr_data.prio;
      if (wr_en.round) rec_mem[wr_addr].round <= wr_data.round;
      if (wr_en.epoch) rec_mem[wr_addr].epoch <= wr_data.epoch;
      if (wr_en.wake)  rec_mem[wr_addr].wake  <= wr_data.wake;
   end

   // Registered read; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= rec_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### hw/rtl/pbts_queue_ram.sv
// Queue head and tail memory, one entry per round and priority.
// Registered read port, one write port with head and tail enables. Uses pbts_pkg.
module pbts_queue_ram (
   input  logic                                clock,
   input  logic                                rd_en,
   input  logic [pbts_pkg::QADDR_BITS-1:0]     rd_addr,
   output pbts_pkg::q_entry_type               rd_data,
   input  pbts_pkg::q_we_type                  wr_en,
   input  logic [pbts_pkg::QADDR_BITS-1:0]     wr_addr,
   input  pbts_pkg::q_entry_type               wr_data
);
   import pbts_pkg::*;

   q_entry_type q_mem [2*NUM_PRIOS];
   q_entry_type rd_data_ff;

   // Field-wise writes.
   always_ff @(posedge clock) begin
      if (wr_en.head) q_mem[wr_addr].head <= wr_data.head;
      if (wr_en.tail) q_mem[wr_addr].tail <= wr_data.tail;
   end

   // Registered read.
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= q_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### hw/rtl/pbts_core.sv
// Scheduler sequencer: walks queue and wake-list operations over the two memories.
// Depends on pbts_pkg, pbts_task_ram and pbts_queue_ram.
module pbts_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  pbts_pkg::item_type               item,
   input  logic [pbts_pkg::CFG_BITS-1:0]    default_epoch,
   output logic                             idle,
   output logic                             res_valid,
   input  logic                             res_ready,
   output pbts_pkg::res_type                res
);
   import pbts_pkg::*;

   // Control state.
   state_type state_ff, state_in, ret_ff, ret_in;
   logic [TICK_BITS-1:0] tick_ff, tick_in, nw_ff, nw_in;
   logic [1:0][NUM_PRIOS-1:0] map_ff, map_in;
   logic rs_ff, rs_in, wls_ff, wls_in;
   logic [1:0][LINK_BITS-1:0] wlh_ff, wlh_in;
   logic [TASK_BITS-1:0] run_ff, run_in;
   logic [NUM_TASKS-1:0] resched_ff, resched_in;
   where_type where_ff [NUM_TASKS];
   where_type where_in [NUM_TASKS];

   // Working registers of the current item.
   item_type item_ff, item_in;
   logic [TASK_BITS-1:0] t_ff, t_in, tl_ff, tl_in;
   logic r_ff, r_in, list_ff, list_in;
   logic [PRIO_BITS-1:0] p_ff, p_in;
   logic [LINK_BITS-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic [WOKEN_BITS-1:0] guard_ff, guard_in, woken_ff, woken_in;
   logic [TICK_BITS-1:0] wake_ff, wake_in;
   logic status_ff, status_in, switched_ff, switched_in;

   // Memory ports.
   logic t_re, q_re;
   logic [TASK_BITS-1:0] t_raddr, t_waddr;
   task_rec_type t_rdata, t_wdata;
   rec_we_type t_we;
   logic [QADDR_BITS-1:0] q_raddr, q_waddr;
   q_entry_type q_rdata, q_wdata;
   q_we_type q_we;

   pbts_task_ram u_task_ram (
      .clock   (clock),
      .rd_en   (t_re),
      .rd_addr (t_raddr),
      .rd_data (t_rdata),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (t_wdata)
   );

   pbts_queue_ram u_queue_ram (
      .clock   (clock),
      .rd_en   (q_re),
      .rd_addr (q_raddr),
      .rd_data (q_rdata),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata)
   );

   // Shared decode terms.
   logic run_idle, map_any, sched_skip, ready_rej, delay_rej;
   logic wl_stop, ins_go, ins_before, wake_ovf, pv_ok, nx_ok, epoch_le0;
   logic [PRIO_BITS-1:0] top_prio, sat_prio;
   logic [TICK_BITS-1:0] tick_inc, wake_sum;
   logic [LINK_BITS-1:0] wl_head, new_head;
   logic [EPOCH_BITS-1:0] epoch_dec;

   assign run_idle   = (run_ff == IDLE_TASK);
   assign map_any    = |map_ff[rs_ff];
   assign top_prio   = hi_bit(map_ff[rs_ff]);
   assign sched_skip = !run_idle && !resched_ff[run_ff];
   assign ready_rej  = (item.task_id == IDLE_TASK) || (where_ff[item.task_id] != WH_NONE);
   assign delay_rej  = run_idle || (where_ff[run_ff] != WH_QUEUE);
   assign sat_prio   = (item.priority_req > MAX_PRIO) ? MAX_PRIO : item.priority_req;
   assign tick_inc   = tick_ff + TICK_BITS'(1);
   assign wake_sum   = tick_ff + TICK_BITS'(item_ff.delay_ticks);
   assign wake_ovf   = (wake_sum < tick_ff);
   assign wl_head    = wlh_ff[wls_ff];
   assign new_head   = wlh_ff[~wls_ff];
   assign wl_stop    = wl_head[TASK_BITS] || (woken_ff >= WOKEN_BITS'(NUM_TASKS));
   assign ins_go     = !cur_ff[TASK_BITS] && (guard_ff < WOKEN_BITS'(NUM_TASKS));
   assign ins_before = (wake_ff < t_rdata.wake);
   assign pv_ok      = !t_rdata.prev[TASK_BITS];
   assign nx_ok      = !t_rdata.next[TASK_BITS];
   assign epoch_dec  = (t_rdata.epoch == EPOCH_MIN) ? t_rdata.epoch
                                                    : t_rdata.epoch - EPOCH_BITS'(1);
   assign epoch_le0  = t_rdata.epoch[EPOCH_BITS-1] || (t_rdata.epoch == '0);

   // Next state and return point of the push and remove sub-sequences.
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (item.command)
                  CMD_TICK:  state_in = run_idle ? ST_T_ADV : ST_T_EPOCH;
                  CMD_SCHED: begin
                     if (sched_skip)      state_in = ST_FINISH;
                     else if (map_any)    state_in = ST_S_HEAD;
                     else if (run_idle)   state_in = ST_FINISH;
                     else                 state_in = ST_S_OLD;
                  end
                  CMD_READY: begin
                     if (ready_rej) begin
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_PUSH_START;
                        ret_in   = ST_FINISH;
                     end
                  end
                  CMD_DELAY: begin
                     if (delay_rej) begin
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_RM_A;
                        ret_in   = ST_D_SET;
                     end
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_T_EPOCH: state_in = ST_T_ADV;
         ST_T_ADV: begin
            if (tick_inc == '0 && !new_head[TASK_BITS]) state_in = ST_T_REFR;
            else                                         state_in = ST_T_CHK;
         end
         ST_T_REFR:  state_in = ST_T_CHK;
         ST_T_CHK:   state_in = (tick_ff >= nw_ff) ? ST_T_WLOOP : ST_FINISH;
         ST_T_WLOOP: state_in = wl_stop ? ST_FINISH : ST_T_WCHK;
         ST_T_WCHK: begin
            if (tick_ff < t_rdata.wake) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_PUSH_START;
               ret_in   = ST_T_WLOOP;
            end
         end
         ST_S_HEAD: begin
            state_in = ST_RM_A;
            ret_in   = ST_S_PUSH;
         end
         ST_S_PUSH: begin
            state_in = ST_PUSH_START;
            ret_in   = ST_S_CHK;
         end
         ST_S_CHK: begin
            if (t_ff == run_ff)  state_in = ST_FINISH;
            else if (!run_idle)  state_in = ST_S_OLD;
            else                 state_in = ST_FINISH;
         end
         ST_S_OLD:   state_in = ST_FINISH;
         ST_D_SET:   state_in = ST_W_STEP;
         ST_W_STEP:  state_in = ins_go ? ST_W_CMP : ST_W_LINK;
         ST_W_CMP:   state_in = ins_before ? ST_W_LINK : ST_W_STEP;
         ST_W_LINK:  state_in = prev_ff[TASK_BITS] ? ST_FINISH : ST_W_LINK2;
         ST_W_LINK2: state_in = ST_FINISH;
         ST_PUSH_START: state_in = map_ff[r_ff][p_ff] ? ST_PUSH_TAIL : ret_ff;
         ST_PUSH_TAIL:  state_in = ST_PUSH_LINK;
         ST_PUSH_LINK:  state_in = ret_ff;
         ST_RM_A:       state_in = ST_RM_B;
         ST_RM_B:       state_in = ret_ff;
         ST_FINISH:     if (res_ready) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory accesses and state updates.
   always_comb begin
      tick_in     = tick_ff;
      nw_in       = nw_ff;
      map_in      = map_ff;
      rs_in       = rs_ff;
      wls_in      = wls_ff;
      wlh_in      = wlh_ff;
      run_in      = run_ff;
      resched_in  = resched_ff;
      where_in    = where_ff;
      item_in     = item_ff;
      t_in        = t_ff;
      tl_in       = tl_ff;
      r_in        = r_ff;
      p_in        = p_ff;
      list_in     = list_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      guard_in    = guard_ff;
      woken_in    = woken_ff;
      wake_in     = wake_ff;
      status_in   = status_ff;
      switched_in = switched_ff;
      t_re        = 1'b0;
      t_raddr     = t_ff;
      t_we        = '0;
      t_waddr     = t_ff;
      t_wdata     = '0;
      q_re        = 1'b0;
      q_raddr     = {r_ff, p_ff};
      q_we        = '0;
      q_waddr     = {r_ff, p_ff};
      q_wdata     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in     = item;
               status_in   = 1'b0;
               switched_in = 1'b0;
               woken_in    = '0;
               case (item.command)
                  CMD_TICK: begin
                     t_re    = !run_idle;
                     t_raddr = run_ff;
                  end
                  CMD_SCHED: begin
                     if (!sched_skip) begin
                        if (map_any) begin
                           q_re    = 1'b1;
                           q_raddr = {rs_ff, top_prio};
                        end else begin
                           // Current round empty: swap rounds, idle task runs.
                           rs_in   = ~rs_ff;
                           t_in    = IDLE_TASK;
                           t_re    = !run_idle;
                           t_raddr = run_ff;
                        end
                     end
                  end
                  CMD_READY: begin
                     if (ready_rej) begin
                        status_in = 1'b1;
                     end else begin
                        t_we.prio     = 1'b1;
                        t_we.epoch    = 1'b1;
                        t_waddr       = item.task_id;
                        t_wdata.prio  = sat_prio;
                        t_wdata.epoch = EPOCH_BITS'(default_epoch);
                        t_in          = item.task_id;
                        p_in          = sat_prio;
                        r_in          = item.to_next_round ? ~rs_ff : rs_ff;
                     end
                  end
                  CMD_DELAY: begin
                     if (delay_rej) begin
                        status_in = 1'b1;
                     end else begin
                        t_in    = run_ff;
                        t_re    = 1'b1;
                        t_raddr = run_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // Count down the running task's epoch.
         ST_T_EPOCH: begin
            t_we.epoch    = 1'b1;
            t_waddr       = run_ff;
            t_wdata.epoch = epoch_dec;
            if (epoch_dec[EPOCH_BITS-1] || epoch_dec == '0) resched_in[run_ff] = 1'b1;
         end

         // Advance the tick; on wrap swap the wake lists.
         ST_T_ADV: begin
            tick_in = tick_inc;
            if (tick_inc == '0) begin
               wls_in = ~wls_ff;
               if (new_head[TASK_BITS]) begin
                  nw_in = NEVER;
               end else begin
                  t_re    = 1'b1;
                  t_raddr = new_head[TASK_BITS-1:0];
               end
            end
         end
         ST_T_REFR: nw_in = t_rdata.wake;

         // Wake due tasks from the head of the current list.
         ST_T_WLOOP: begin
            if (wl_stop) begin
               nw_in = NEVER;
            end else begin
               t_in    = wl_head[TASK_BITS-1:0];
               t_re    = 1'b1;
               t_raddr = wl_head[TASK_BITS-1:0];
            end
         end
         ST_T_WCHK: begin
            if (tick_ff < t_rdata.wake) begin
               nw_in = t_rdata.wake;
            end else begin
               wlh_in[wls_ff] = t_rdata.next;
               woken_in       = woken_ff + WOKEN_BITS'(1);
               r_in           = t_rdata.round;
               p_in           = t_rdata.prio;
            end
         end

         // Schedule: remove the picked head, then requeue it in the other round.
         ST_S_HEAD: begin
            t_in    = q_rdata.head;
            t_re    = 1'b1;
            t_raddr = q_rdata.head;
         end
         ST_S_PUSH: r_in = ~rs_ff;
         ST_S_CHK: begin
            if (t_ff != run_ff) begin
               if (!run_idle) begin
                  t_re    = 1'b1;
                  t_raddr = run_ff;
               end else begin
                  run_in      = t_ff;
                  switched_in = 1'b1;
               end
            end
         end
         ST_S_OLD: begin
            resched_in[run_ff] = 1'b0;
            if (epoch_le0) begin
               t_we.epoch    = 1'b1;
               t_waddr       = run_ff;
               t_wdata.epoch = EPOCH_BITS'(default_epoch);
            end
            run_in      = t_ff;
            switched_in = 1'b1;
         end

         // Delay: set the wake time and start the sorted walk.
         ST_D_SET: begin
            t_we.wake          = 1'b1;
            t_wdata.wake       = wake_sum;
            resched_in[t_ff]   = 1'b1;
            wake_in            = wake_sum;
            list_in            = wake_ovf ? ~wls_ff : wls_ff;
            cur_in             = wake_ovf ? wlh_ff[~wls_ff] : wlh_ff[wls_ff];
            prev_in            = LINK_NIL;
            guard_in           = '0;
            if (!wake_ovf && wake_sum < nw_ff) nw_in = wake_sum;
         end
         ST_W_STEP: begin
            t_re    = ins_go;
            t_raddr = cur_ff[TASK_BITS-1:0];
         end
         ST_W_CMP: begin
            if (!ins_before) begin
               prev_in  = cur_ff;
               cur_in   = t_rdata.next;
               guard_in = guard_ff + WOKEN_BITS'(1);
            end
         end
         ST_W_LINK: begin
            t_we.next    = 1'b1;
            t_wdata.next = cur_ff;
            if (prev_ff[TASK_BITS]) begin
               wlh_in[list_ff] = {1'b0, t_ff};
               where_in[t_ff]  = WH_DELAY;
            end
         end
         ST_W_LINK2: begin
            t_we.next      = 1'b1;
            t_waddr        = prev_ff[TASK_BITS-1:0];
            t_wdata.next   = {1'b0, t_ff};
            where_in[t_ff] = WH_DELAY;
         end

         // Push task t_ff at the tail of queue (r_ff, p_ff).
         ST_PUSH_START: begin
            if (map_ff[r_ff][p_ff]) begin
               q_re = 1'b1;
            end else begin
               t_we.next     = 1'b1;
               t_we.prev     = 1'b1;
               t_we.round    = 1'b1;
               t_wdata.next  = LINK_NIL;
               t_wdata.prev  = LINK_NIL;
               t_wdata.round = r_ff;
               q_we.head     = 1'b1;
               q_we.tail     = 1'b1;
               q_wdata.head  = t_ff;
               q_wdata.tail  = t_ff;
               map_in[r_ff][p_ff] = 1'b1;
               where_in[t_ff]     = WH_QUEUE;
            end
         end
         ST_PUSH_TAIL: begin
            t_we.next     = 1'b1;
            t_we.prev     = 1'b1;
            t_we.round    = 1'b1;
            t_wdata.next  = LINK_NIL;
            t_wdata.prev  = {1'b0, q_rdata.tail};
            t_wdata.round = r_ff;
            tl_in         = q_rdata.tail;
         end
         ST_PUSH_LINK: begin
            t_we.next      = 1'b1;
            t_waddr        = tl_ff;
            t_wdata.next   = {1'b0, t_ff};
            q_we.tail      = 1'b1;
            q_wdata.tail   = t_ff;
            where_in[t_ff] = WH_QUEUE;
         end

         // Unlink task t_ff; its record is in the read register.
         ST_RM_A: begin
            r_in = t_rdata.round;
            p_in = t_rdata.prio;
            if (pv_ok) begin
               t_we.next    = 1'b1;
               t_waddr      = t_rdata.prev[TASK_BITS-1:0];
               t_wdata.next = t_rdata.next;
            end
         end
         ST_RM_B: begin
            if (nx_ok) begin
               t_we.prev    = 1'b1;
               t_waddr      = t_rdata.next[TASK_BITS-1:0];
               t_wdata.prev = t_rdata.prev;
            end
            q_we.head    = !pv_ok;
            q_we.tail    = !nx_ok;
            q_wdata.head = t_rdata.next[TASK_BITS-1:0];
            q_wdata.tail = t_rdata.prev[TASK_BITS-1:0];
            if (!pv_ok && !nx_ok) map_in[r_ff][p_ff] = 1'b0;
            where_in[t_ff] = WH_NONE;
         end

         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ret_ff     <= ST_FINISH;
         tick_ff    <= '0;
         nw_ff      <= NEVER;
         map_ff     <= '0;
         rs_ff      <= 1'b0;
         wls_ff     <= 1'b0;
         wlh_ff     <= {LINK_NIL, LINK_NIL};
         run_ff     <= IDLE_TASK;
         resched_ff <= '0;
         for (int i = 0; i < NUM_TASKS; i++) where_ff[i] <= WH_NONE;
      end else begin
         state_ff   <= state_in;
         ret_ff     <= ret_in;
         tick_ff    <= tick_in;
         nw_ff      <= nw_in;
         map_ff     <= map_in;
         rs_ff      <= rs_in;
         wls_ff     <= wls_in;
         wlh_ff     <= wlh_in;
         run_ff     <= run_in;
         resched_ff <= resched_in;
         where_ff   <= where_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      t_ff        <= t_in;
      tl_ff       <= tl_in;
      r_ff        <= r_in;
      p_ff        <= p_in;
      list_ff     <= list_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      guard_ff    <= guard_in;
      woken_ff    <= woken_in;
      wake_ff     <= wake_in;
      status_ff   <= status_in;
      switched_ff <= switched_in;
   end

   // Result of the finished item.
   always_comb begin
      idle                = (state_ff == ST_IDLE);
      res_valid           = (state_ff == ST_FINISH);
      res.status          = status_ff;
      res.switched        = switched_ff;
      res.running_task    = run_ff;
      res.woken_count     = woken_ff;
      res.resched_pending = run_idle || resched_ff[run_ff];
   end
endmodule
